[rtl/pli_pkg.sv]
// shared types and constants for the positional list block
`timescale 1ns / 1ps

package pli_pkg;

  localparam int PLI_DEPTH  = 32;
  localparam int POS_W      = 6;
  localparam int VAL_W      = 32;
  localparam int QUEUE_SLOTS = 2;

  // request codes on the input channel
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [POS_W-1:0]  position;
    logic signed [VAL_W-1:0] value;
  } pli_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [VAL_W-1:0] entry;
    logic              last;
  } pli_out_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [POS_W-1:0]  pos;
    logic signed [VAL_W-1:0] value;
  } pli_cmd_t;

  typedef struct packed {
    logic     valid;
    pli_cmd_t cmd;
  } pli_head_t;

endpackage

[rtl/pli_front.sv]
// request decode and two-slot command queue
`timescale 1ns / 1ps

module pli_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pli_pkg::pli_in_t in_item,
  output pli_pkg::pli_head_t head,
  input  logic            pop
);
  import pli_pkg::*;

  localparam int PW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int LW = $clog2(QUEUE_SLOTS + 1);

  pli_cmd_t        slot_r [QUEUE_SLOTS];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]   level_r, level_nxt;
  pli_cmd_t        dec_cmd;
  logic            dec_ok;
  logic            push;
  logic            do_pop;

  // classify the request; the unused code is dropped here
  always_comb begin
    dec_cmd.pos   = in_item.position;
    dec_cmd.value = in_item.value;
    dec_cmd.kind  = CMD_DUMP;
    dec_ok        = 1'b1;
    case (in_item.req_type)
      REQ_INSERT: dec_cmd.kind = CMD_INSERT;
      REQ_DELETE: dec_cmd.kind = CMD_DELETE;
      REQ_DUMP:   dec_cmd.kind = CMD_DUMP;
      default:    dec_ok = 1'b0;
    endcase
  end

  assign busy   = (level_r == LW'(QUEUE_SLOTS));
  assign push   = start && !busy && dec_ok;
  assign do_pop = pop && (level_r != '0);

  assign head.valid = (level_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_SLOTS - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_SLOTS - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !do_pop) begin
      level_nxt = LW'(level_r + 1'b1);
    end else if (do_pop && !push) begin
      level_nxt = LW'(level_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

[rtl/pli_back.sv]
// list engine: shift chain store, fill count and result register
`timescale 1ns / 1ps

module pli_back #(
  parameter int DEPTH = pli_pkg::PLI_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pli_pkg::pli_head_t head,
  output logic               pop,
  output logic               out_valid,
  output pli_pkg::pli_out_t  out_res
);
  import pli_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [VAL_W-1:0]  store_r   [DEPTH];
  logic signed [VAL_W-1:0]  store_nxt [DEPTH];
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  pli_out_t                 out_res_r, out_res_nxt;
  logic [CMPW-1:0]          pos_ext;
  logic [CMPW-1:0]          cnt_ext;
  logic                     is_full;
  logic                     ins_bad;
  logic                     del_bad;
  logic                     do_ins;
  logic                     do_del;
  logic                     do_rot;
  logic                     dump_end;

  assign pos_ext  = CMPW'(head.cmd.pos);
  assign cnt_ext  = CMPW'(count_r);
  assign is_full  = (count_r == CW'(DEPTH));
  assign ins_bad  = (pos_ext == '0) || (pos_ext > CMPW'(cnt_ext + 1'b1));
  assign del_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign dump_end = (CW'(idx_r + 1'b1) == count_r);
  assign pop      = (state_r == S_IDLE) && head.valid;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    do_ins        = 1'b0;
    do_del        = 1'b0;
    do_rot        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          out_valid_nxt    = 1'b1;
          out_res_nxt.last = 1'b1;
          case (head.cmd.kind)
            CMD_INSERT: begin
              if (is_full) begin
                out_res_nxt.status = STAT_FULL;
              end else if (ins_bad) begin
                out_res_nxt.status = STAT_BAD;
              end else begin
                out_res_nxt.status = STAT_OK;
                do_ins    = 1'b1;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                out_res_nxt.status = STAT_EMPTY;
              end else if (del_bad) begin
                out_res_nxt.status = STAT_BAD;
              end else begin
                out_res_nxt.status = STAT_OK;
                do_del    = 1'b1;
                count_nxt = CW'(count_r - 1'b1);
              end
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                out_res_nxt.status = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                idx_nxt       = '0;
                state_nxt     = S_DUMP;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      S_DUMP: begin
        // head of the chain goes out, the filled part rotates by one
        out_valid_nxt      = 1'b1;
        out_res_nxt.status = STAT_OK;
        out_res_nxt.entry  = store_r[0];
        out_res_nxt.last   = dump_end;
        do_rot             = 1'b1;
        idx_nxt            = CW'(idx_r + 1'b1);
        if (dump_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      store_nxt[i] = store_r[i];
      if (do_ins) begin
        if (CMPW'(i + 1) == pos_ext) begin
          store_nxt[i] = head.cmd.value;
        end else if ((CMPW'(i) >= pos_ext) && (i > 0)) begin
          store_nxt[i] = store_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if ((CMPW'(i + 1) >= pos_ext) && (i < DEPTH - 1)) begin
          store_nxt[i] = store_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if (do_rot) begin
        if (CW'(i + 1) == count_r) begin
          store_nxt[i] = store_r[0];
        end else if ((CW'(i + 1) < count_r) && (i < DEPTH - 1)) begin
          store_nxt[i] = store_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    for (int i = 0; i < DEPTH; i++) begin
      store_r[i] <= store_nxt[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[rtl/positional_list_insert_delete.sv]
// top level of the positional list: decode queue in front, list engine behind
//
//   channel  ports                          beat taken when
//   input    start, busy, in_item           start high and busy low
//   result   out_valid, out_res             out_valid high (one cycle each)
//
// an insert or delete gives its result through the queue slot and then the
// engine's result register when the engine is free; a dump gives one result
// per stored entry, one a cycle, and an empty dump gives one. the engine's
// shift chain sets the pace. busy rises when both queue slots hold commands;
// reset empties the list. results cannot be stalled.
`timescale 1ns / 1ps

module positional_list_insert_delete #(
  parameter int DEPTH = pli_pkg::PLI_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pli_pkg::pli_in_t  in_item,
  output logic              out_valid,
  output pli_pkg::pli_out_t out_res
);
  import pli_pkg::*;

  pli_head_t head;
  logic      pop;

  pli_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  pli_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
